// ===== src/art_pkg.sv =====
// ----------------------------------------------------------------------------
// art_pkg
// Types and codes shared by the address region table modules.
// ----------------------------------------------------------------------------
package art_pkg;

   localparam int ADDR_W  = 32;
   localparam int USED_W  = 7;
   localparam int FLAG_W  = 4;
   localparam int CSR_IDX_W = 2;

   localparam logic [1:0] OP_MAP   = 2'd0;
   localparam logic [1:0] OP_FIND  = 2'd1;
   localparam logic [1:0] OP_CHECK = 2'd2;
   localparam logic [1:0] OP_CLEAR = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_DENIED  = 2'd1;
   localparam logic [1:0] ST_INVALID = 2'd2;
   localparam logic [1:0] ST_FULL    = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_USER_BASE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_USER_TOP  = 2'd1;

   localparam logic [ADDR_W-1:0] USER_BASE_RST = 32'h0020_0000;
   localparam logic [ADDR_W-1:0] USER_TOP_RST  = 32'hB000_0000;

   localparam int PERM_READ  = 0;
   localparam int PERM_WRITE = 1;
   localparam int PERM_STACK = 3;

   typedef struct packed {
      logic [1:0]        opcode;
      logic [ADDR_W-1:0] address;
      logic [ADDR_W-1:0] length;
      logic [FLAG_W-1:0] region_flags;
      logic              write_access;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [ADDR_W-1:0] found_start;
      logic [ADDR_W-1:0] found_end;
      logic [FLAG_W-1:0] found_flags;
      logic [USED_W-1:0] entries_used;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_W-1:0] region_start;
      logic [ADDR_W-1:0] region_end;
      logic [FLAG_W-1:0] perm;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PREP,
      S_READ,
      S_EVAL,
      S_PLACE,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_INSERT_DONE
   } seq_state_type;

endpackage

// ===== src/art_table_ram.sv =====
// ----------------------------------------------------------------------------
// art_table_ram
// Region entry store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module art_table_ram #(
   parameter int DEPTH = 64,
   parameter int IDX_W = 6
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [IDX_W-1:0]    wr_addr,
   input  art_pkg::entry_type  wr_data,
   input  logic                rd_en,
   input  logic [IDX_W-1:0]    rd_addr,
   output art_pkg::entry_type  rd_data
);
   import art_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/art_ctrl.sv =====
// ----------------------------------------------------------------------------
// art_ctrl
// Sequencer and shared compare datapath: walks the table one entry at a time.
// ----------------------------------------------------------------------------
module art_ctrl #(
   parameter int MAX_REGIONS = 64,
   parameter int PAGE_BITS   = 12,
   parameter int IDX_W       = 6,
   parameter int CNT_W       = 7
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  art_pkg::req_type     req_data,
   output logic                 req_stall,
   input  logic [31:0]          user_base,
   input  logic [31:0]          user_top,
   output logic                 done_valid,
   output art_pkg::rsp_type     done_data,
   input  logic                 done_take,
   output logic                 ram_wr_en,
   output logic [IDX_W-1:0]     ram_wr_addr,
   output art_pkg::entry_type   ram_wr_data,
   output logic                 ram_rd_en,
   output logic [IDX_W-1:0]     ram_rd_addr,
   input  art_pkg::entry_type   ram_rd_data
);
   import art_pkg::*;

   localparam logic [ADDR_W-1:0] PG_OFF  = (ADDR_W'(1) << PAGE_BITS) - ADDR_W'(1);
   localparam logic [ADDR_W-1:0] PG_SIZE = ADDR_W'(1) << PAGE_BITS;
   localparam logic [CNT_W-1:0]  MAX_CNT = CNT_W'(MAX_REGIONS);

   seq_state_type state_ff, state_in;
   req_type       item_ff, item_in;
   logic [ADDR_W-1:0] cur_ff, cur_in, lim_ff, lim_in;
   logic [CNT_W-1:0]  idx_ff, idx_in, pos_ff, pos_in, total_ff, total_in;
   logic [1:0]        stat_ff, stat_in;
   entry_type         res_ff, res_in;

   logic [ADDR_W-1:0] sum_len, map_start, map_end;
   logic              map_win, chk_win;
   logic [CNT_W-1:0]  idx_inc, idx_dec;
   logic              last, overlap, contains, beyond, perm_ok, guard_hit;
   entry_type         ent;

   assign ent       = ram_rd_data;
   assign sum_len   = item_ff.address + item_ff.length;
   assign map_start = item_ff.address & ~PG_OFF;
   assign map_end   = (sum_len + PG_OFF) & ~PG_OFF;
   assign map_win   = (user_base <= map_start) && (map_start < map_end) &&
                      (map_end <= user_top);
   assign chk_win   = (user_base <= item_ff.address) && (item_ff.address < sum_len) &&
                      (sum_len <= user_top);
   assign idx_inc   = idx_ff + CNT_W'(1);
   assign idx_dec   = idx_ff - CNT_W'(1);
   assign last      = (idx_inc == total_ff);
   assign overlap   = (ent.region_start < lim_ff) && (cur_ff < ent.region_end);
   assign contains  = (ent.region_start <= cur_ff) && (cur_ff < ent.region_end);
   assign beyond    = (ent.region_start > cur_ff);
   assign perm_ok   = item_ff.write_access ? ent.perm[PERM_WRITE] : ent.perm[PERM_READ];
   // first page of a stack region is the guard page
   assign guard_hit = item_ff.write_access && ent.perm[PERM_STACK] &&
                      ((cur_ff - ent.region_start) < PG_SIZE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         total_ff <= '0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      cur_ff  <= cur_in;
      lim_ff  <= lim_in;
      idx_ff  <= idx_in;
      pos_ff  <= pos_in;
      stat_ff <= stat_in;
      res_ff  <= res_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_PREP;
         end
         S_PREP: begin
            case (item_ff.opcode)
               OP_MAP: begin
                  if (!map_win) state_in = S_INSERT_DONE;
                  else if (total_ff == '0) state_in = S_PLACE;
                  else state_in = S_READ;
               end
               OP_FIND: state_in = (total_ff == '0) ? S_INSERT_DONE : S_READ;
               OP_CHECK: begin
                  if (!chk_win || total_ff == '0) state_in = S_INSERT_DONE;
                  else state_in = S_READ;
               end
               default: state_in = S_INSERT_DONE;
            endcase
         end
         S_READ: state_in = S_EVAL;
         S_EVAL: begin
            case (item_ff.opcode)
               OP_MAP: begin
                  if (overlap) state_in = S_INSERT_DONE;
                  else if (last) state_in = S_PLACE;
                  else state_in = S_READ;
               end
               OP_FIND: begin
                  if (contains || beyond || last) state_in = S_INSERT_DONE;
                  else state_in = S_READ;
               end
               default: begin
                  if (contains) begin
                     if (!perm_ok || guard_hit || ent.region_end >= lim_ff || last)
                        state_in = S_INSERT_DONE;
                     else
                        state_in = S_READ;
                  end else if (beyond || last) begin
                     state_in = S_INSERT_DONE;
                  end else begin
                     state_in = S_READ;
                  end
               end
            endcase
         end
         S_PLACE: begin
            if (total_ff >= MAX_CNT) state_in = S_INSERT_DONE;
            else if (pos_ff == total_ff) state_in = S_INSERT_DONE;
            else state_in = S_SHIFT_RD;
         end
         S_SHIFT_RD: state_in = S_SHIFT_WR;
         S_SHIFT_WR: state_in = (idx_dec == pos_ff) ? S_INSERT_DONE : S_SHIFT_RD;
         S_INSERT_DONE: begin
            if (done_take) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // register updates
   always_comb begin
      item_in  = item_ff;
      cur_in   = cur_ff;
      lim_in   = lim_ff;
      idx_in   = idx_ff;
      pos_in   = pos_ff;
      total_in = total_ff;
      stat_in  = stat_ff;
      res_in   = res_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) item_in = req_data;
         end
         S_PREP: begin
            idx_in = '0;
            pos_in = '0;
            res_in = '0;
            case (item_ff.opcode)
               OP_MAP: begin
                  cur_in  = map_start;
                  lim_in  = map_end;
                  stat_in = map_win ? ST_OK : ST_INVALID;
               end
               OP_FIND: begin
                  cur_in  = item_ff.address;
                  stat_in = ST_DENIED;
               end
               OP_CHECK: begin
                  cur_in  = item_ff.address;
                  lim_in  = sum_len;
                  stat_in = ST_DENIED;
               end
               default: begin
                  total_in = '0;
                  stat_in  = ST_OK;
               end
            endcase
         end
         S_EVAL: begin
            idx_in = idx_inc;
            case (item_ff.opcode)
               OP_MAP: begin
                  if (ent.region_start <= cur_ff) pos_in = idx_inc;
                  if (overlap) stat_in = ST_INVALID;
               end
               OP_FIND: begin
                  if (contains) begin
                     stat_in = ST_OK;
                     res_in  = ent;
                  end
               end
               default: begin
                  if (contains && perm_ok && !guard_hit) begin
                     cur_in = ent.region_end;
                     if (ent.region_end >= lim_ff) stat_in = ST_OK;
                  end
               end
            endcase
         end
         S_PLACE: begin
            idx_in = total_ff;
            if (total_ff >= MAX_CNT) stat_in = ST_FULL;
         end
         S_SHIFT_WR: idx_in = idx_dec;
         S_INSERT_DONE: begin
            // first cycle here after a successful placement writes the entry
            if (item_ff.opcode == OP_MAP && stat_ff == ST_OK && res_ff == '0) begin
               res_in   = '{region_start: cur_ff, region_end: lim_ff,
                            perm: item_ff.region_flags};
               total_in = total_ff + CNT_W'(1);
            end
         end
         default: ;
      endcase
   end

   logic insert_now;
   // map results always carry a nonzero end, so a zero result marks the write cycle
   assign insert_now = (state_ff == S_INSERT_DONE) && (item_ff.opcode == OP_MAP) &&
                       (stat_ff == ST_OK) && (res_ff == '0);

   // outputs
   always_comb begin
      req_stall   = (state_ff != S_IDLE);
      ram_rd_en   = 1'b0;
      ram_rd_addr = idx_ff[IDX_W-1:0];
      ram_wr_en   = 1'b0;
      ram_wr_addr = idx_ff[IDX_W-1:0];
      ram_wr_data = ram_rd_data;
      done_valid  = 1'b0;
      case (state_ff)
         S_READ: ram_rd_en = 1'b1;
         S_SHIFT_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = idx_dec[IDX_W-1:0];
         end
         S_SHIFT_WR: ram_wr_en = 1'b1;
         S_INSERT_DONE: begin
            ram_wr_en   = insert_now;
            ram_wr_addr = pos_ff[IDX_W-1:0];
            ram_wr_data = '{region_start: cur_ff, region_end: lim_ff,
                            perm: item_ff.region_flags};
            done_valid  = !insert_now;
         end
         default: ;
      endcase
   end

   assign done_data = '{status: stat_ff, found_start: res_ff.region_start,
                        found_end: res_ff.region_end, found_flags: res_ff.perm,
                        entries_used: USED_W'(total_ff)};

endmodule

// ===== src/address_region_table.sv =====
// ----------------------------------------------------------------------------
// address_region_table
// Sorted table of non-overlapping address regions: map, find, check, clear.
// ----------------------------------------------------------------------------
//  channel | ports                          | direction
//  req     | req_valid req_stall req_data   | in (item)
//  rsp     | rsp_valid rsp_stall rsp_data   | out (item)
//  csr     | csr_valid csr_ready csr_index  | in (register write)
//          | csr_data                       |
//
// One item at a time. Each table entry visited is read through the single
// read port of the entry RAM and then evaluated (S_READ, S_EVAL); map, find and
// check walk up to MAX_REGIONS entries, and an insert shifts up to MAX_REGIONS-1
// entries, each with a read step and a write step (S_SHIFT_RD, S_SHIFT_WR).
// Reset is synchronous; the entry RAM needs no clearing pass.
// An output register holds the item, so a stalled result does not block the
// next request.
module address_region_table #(
   parameter int MAX_REGIONS = 64,
   parameter int PAGE_BITS   = 12
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  art_pkg::req_type    req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output art_pkg::rsp_type    rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_data
);
   import art_pkg::*;

   localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
   localparam int CNT_W = $clog2(MAX_REGIONS + 1);

   logic [ADDR_W-1:0] user_base_ff, user_top_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;
   logic              done_valid, done_take;
   rsp_type           done_data;
   logic              ram_wr_en, ram_rd_en;
   logic [IDX_W-1:0]  ram_wr_addr, ram_rd_addr;
   entry_type         ram_wr_data, ram_rd_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         user_base_ff <= USER_BASE_RST;
         user_top_ff  <= USER_TOP_RST;
      end else if (csr_valid) begin
         if (csr_index == CSR_USER_BASE) user_base_ff <= csr_data;
         if (csr_index == CSR_USER_TOP)  user_top_ff  <= csr_data;
      end
   end

   assign done_take = done_valid && (!rsp_valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done_take) rsp_data_ff <= done_data;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   art_ctrl #(
      .MAX_REGIONS(MAX_REGIONS),
      .PAGE_BITS  (PAGE_BITS),
      .IDX_W      (IDX_W),
      .CNT_W      (CNT_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_data   (req_data),
      .req_stall  (req_stall),
      .user_base  (user_base_ff),
      .user_top   (user_top_ff),
      .done_valid (done_valid),
      .done_data  (done_data),
      .done_take  (done_take),
      .ram_wr_en  (ram_wr_en),
      .ram_wr_addr(ram_wr_addr),
      .ram_wr_data(ram_wr_data),
      .ram_rd_en  (ram_rd_en),
      .ram_rd_addr(ram_rd_addr),
      .ram_rd_data(ram_rd_data)
   );

   art_table_ram #(
      .DEPTH(MAX_REGIONS),
      .IDX_W(IDX_W)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

endmodule

// ===== src/art_checker.sv =====
// ----------------------------------------------------------------------------
// art_checker
// Port-level checks for the address region table.
// ----------------------------------------------------------------------------
module art_checker #(
   parameter int MAX_REGIONS = 64
) (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input art_pkg::rsp_type rsp_data
);
   import art_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK |->
         rsp_data.found_start == '0 && rsp_data.found_end == '0 &&
         rsp_data.found_flags == '0)
      else $error("failed item reports a region");

   a_used_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.entries_used <= USED_W'(MAX_REGIONS))
      else $error("entries_used above table size");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_FULL |->
         rsp_data.entries_used == USED_W'(MAX_REGIONS))
      else $error("table full reported below capacity");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind address_region_table art_checker #(.MAX_REGIONS(MAX_REGIONS)) u_art_checker (
   .clock    (clock),
   .reset    (reset),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_data (rsp_data)
);
